[sv/ipd_pkg.sv]
package ipd_pkg;

  localparam int MAX_PACKET = 2048;
  localparam int POS_W      = $clog2(MAX_PACKET + 1);
  localparam int CMP_W      = ((POS_W > 16) ? POS_W : 16) + 2;
  localparam int SUM_W      = $clog2((MAX_PACKET + 4) * 255 + 1);
  localparam int SUMCMP_W   = (SUM_W > 16) ? SUM_W : 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE = CFG_IDX_W'(1);

  localparam logic [7:0]  SYNC_RESET = 8'hAA;
  localparam logic [15:0] TYPE_RESET = 16'hFF01;
  localparam int          MIN_LENGTH = 5;

  localparam int FLD_FIRST  = 6;
  localparam int FLD_BYTES  = 24;
  localparam int FLD_IDX_W  = $clog2(FLD_BYTES);
  localparam int NAME_FIRST = 30;
  localparam int NAME_BYTES = 8;
  localparam int NAME_CNT_W = $clog2(NAME_BYTES + 1);
  localparam int NAME_IDX_W = $clog2(NAME_BYTES);
  localparam int SUM_FIRST  = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK,
    ST_TOO_SHORT,
    ST_BAD_HEADER,
    ST_OTHER_TYPE,
    ST_BAD_LENGTH,
    ST_BAD_CHECKSUM
  } status_t;

  typedef enum logic [3:0] {
    BK_SYNC,
    BK_LEN_LO,
    BK_LEN_HI,
    BK_TYPE_LO,
    BK_TYPE_HI,
    BK_FIELD,
    BK_NAME,
    BK_TRAIL,
    BK_OVER
  } beat_kind_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    beat_kind_t       kind;
    logic [POS_W-1:0] pos;
  } beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        packet_number;
    logic [31:0]        flag_bits;
    logic [55:0]        time_fields;
    logic [15:0]        speed_hundredths;
    logic signed [31:0] km_post;
    logic [15:0]        serial_number;
    logic signed [7:0]  outside_temp;
    logic [7:0]         heading_status;
    logic [7:0]         carriage_number;
    logic [63:0]        train_number;
  } result_t;

endpackage

[sv/ipd_in_if.sv]
interface ipd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[sv/ipd_out_if.sv]
interface ipd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [15:0]        packet_number;
  logic [31:0]        flag_bits;
  logic [55:0]        time_fields;
  logic [15:0]        speed_hundredths;
  logic signed [31:0] km_post;
  logic [15:0]        serial_number;
  logic signed [7:0]  outside_temp;
  logic [7:0]         heading_status;
  logic [7:0]         carriage_number;
  logic [63:0]        train_number;

  modport source (
    output valid, input ready,
    output status, output packet_number, output flag_bits, output time_fields,
    output speed_hundredths, output km_post, output serial_number,
    output outside_temp, output heading_status, output carriage_number,
    output train_number
  );
  modport sink (
    input valid, output ready,
    input status, input packet_number, input flag_bits, input time_fields,
    input speed_hundredths, input km_post, input serial_number,
    input outside_temp, input heading_status, input carriage_number,
    input train_number
  );
endinterface

[sv/ipd_front.sv]
module ipd_front (
  input  logic          clk,
  input  logic          rst_n,
  ipd_in_if.sink        in_beat,
  input  logic          q_full,
  output logic          q_push,
  output ipd_pkg::beat_t q_beat
);

  logic [ipd_pkg::POS_W-1:0] pos_r, pos_nxt;
  ipd_pkg::beat_kind_t       kind;

  always_comb begin
    if (pos_r >= ipd_pkg::POS_W'(ipd_pkg::MAX_PACKET)) begin
      kind = ipd_pkg::BK_OVER;
    end else if (pos_r < ipd_pkg::POS_W'(2)) begin
      kind = ipd_pkg::BK_SYNC;
    end else if (pos_r == ipd_pkg::POS_W'(2)) begin
      kind = ipd_pkg::BK_LEN_LO;
    end else if (pos_r == ipd_pkg::POS_W'(3)) begin
      kind = ipd_pkg::BK_LEN_HI;
    end else if (pos_r == ipd_pkg::POS_W'(4)) begin
      kind = ipd_pkg::BK_TYPE_LO;
    end else if (pos_r == ipd_pkg::POS_W'(5)) begin
      kind = ipd_pkg::BK_TYPE_HI;
    end else if (pos_r < ipd_pkg::POS_W'(ipd_pkg::NAME_FIRST)) begin
      kind = ipd_pkg::BK_FIELD;
    end else if (pos_r < ipd_pkg::POS_W'(ipd_pkg::NAME_FIRST + ipd_pkg::NAME_BYTES)) begin
      kind = ipd_pkg::BK_NAME;
    end else begin
      kind = ipd_pkg::BK_TRAIL;
    end
  end

  always_comb begin
    in_beat.ready = !q_full;
    q_push        = in_beat.valid && !q_full;
    q_beat.data   = in_beat.data_byte;
    q_beat.last   = in_beat.last_byte;
    q_beat.kind   = kind;
    q_beat.pos    = pos_r;
    pos_nxt       = pos_r;
    if (q_push) begin
      if (in_beat.last_byte) begin
        pos_nxt = '0;
      end else if (kind != ipd_pkg::BK_OVER) begin
        pos_nxt = pos_r + ipd_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

[sv/ipd_queue.sv]
module ipd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ipd_pkg::beat_t push_beat,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ipd_pkg::beat_t head_beat
);

  ipd_pkg::beat_t             entries_r [ipd_pkg::QUEUE_DEPTH];
  logic [ipd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [ipd_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    full       = cnt_r == ipd_pkg::QCNT_W'(ipd_pkg::QUEUE_DEPTH);
    head_valid = cnt_r != '0;
    head_beat  = entries_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ipd_pkg::QPTR_W'(ipd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + ipd_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ipd_pkg::QPTR_W'(ipd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + ipd_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + ipd_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - ipd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_beat;
    end
  end

endmodule

[sv/ipd_back.sv]
module ipd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           beat_valid,
  input  ipd_pkg::beat_t                 beat,
  output logic                           beat_take,
  ipd_out_if.source                      out_beat
);

  logic [7:0]  sync_r, sync_nxt;
  logic [15:0] exp_type_r, exp_type_nxt;

  logic                                          hm_r, hm_nxt;
  logic [15:0]                                   head_r, head_nxt;
  logic [15:0]                                   len_r, len_nxt;
  logic [15:0]                                   type_r, type_nxt;
  logic [ipd_pkg::SUM_W-1:0]                     sum_r, sum_nxt;
  logic [15:0]                                   chk_r, chk_nxt;
  logic [ipd_pkg::FLD_BYTES-1:0][7:0]            fld_r, fld_nxt;
  logic [ipd_pkg::NAME_BYTES-1:0][7:0]           name_r, name_nxt;
  logic [ipd_pkg::NAME_CNT_W-1:0]                ncnt_r, ncnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  ipd_pkg::result_t res_r, res_nxt;

  // values after this beat, before the end-of-packet clear
  logic                                u_hm;
  logic [15:0]                         u_head, u_len, u_type, u_chk;
  logic [ipd_pkg::SUM_W-1:0]           u_sum;
  logic [ipd_pkg::FLD_BYTES-1:0][7:0]  u_fld;
  logic [ipd_pkg::NAME_BYTES-1:0][7:0] u_name;
  logic [ipd_pkg::NAME_CNT_W-1:0]      u_ncnt;

  logic [ipd_pkg::CMP_W-1:0]      pos_w, len_w;
  logic [ipd_pkg::POS_W-1:0]      fld_off, rx_cnt;
  logic                           in_body;
  logic [3:0][7:0]                hb;
  logic [9:0]                     hsum;
  logic [ipd_pkg::SUMCMP_W-1:0]   total;
  logic [15:0]                    chk_fin, len_m1, len_m2;
  ipd_pkg::status_t               st;

  always_comb begin
    sync_nxt     = sync_r;
    exp_type_nxt = exp_type_r;
    if (cfg_we) begin
      case (cfg_index)
        ipd_pkg::CFG_SYNC_BYTE:     sync_nxt = cfg_data[7:0];
        ipd_pkg::CFG_EXPECTED_TYPE: exp_type_nxt = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    beat_take = beat_valid && (!beat.last || !out_valid_r || out_beat.ready);

    u_hm   = hm_r;
    u_head = head_r;
    u_len  = len_r;
    u_type = type_r;
    u_sum  = sum_r;
    u_chk  = chk_r;
    u_fld  = fld_r;
    u_name = name_r;
    u_ncnt = ncnt_r;

    pos_w   = ipd_pkg::CMP_W'(beat.pos);
    len_w   = ipd_pkg::CMP_W'(len_r);
    fld_off = beat.pos - ipd_pkg::POS_W'(ipd_pkg::FLD_FIRST);
    in_body = (beat.kind == ipd_pkg::BK_TYPE_LO) || (beat.kind == ipd_pkg::BK_TYPE_HI) ||
              (beat.kind == ipd_pkg::BK_FIELD) || (beat.kind == ipd_pkg::BK_NAME) ||
              (beat.kind == ipd_pkg::BK_TRAIL);

    case (beat.kind)
      ipd_pkg::BK_SYNC: begin
        if (beat.data != sync_r) begin
          u_hm = 1'b0;
        end
        if (beat.pos[0]) begin
          u_head[15:8] = beat.data;
        end else begin
          u_head[7:0] = beat.data;
        end
      end
      ipd_pkg::BK_LEN_LO:  u_len = {8'h00, beat.data};
      ipd_pkg::BK_LEN_HI:  u_len[15:8] = beat.data;
      ipd_pkg::BK_TYPE_LO: u_type = {8'h00, beat.data};
      ipd_pkg::BK_TYPE_HI: u_type[15:8] = beat.data;
      ipd_pkg::BK_FIELD:   u_fld[fld_off[ipd_pkg::FLD_IDX_W-1:0]] = beat.data;
      ipd_pkg::BK_NAME: begin
        if (beat.data != 8'h00) begin
          u_name[ncnt_r[ipd_pkg::NAME_IDX_W-1:0]] = beat.data;
          u_ncnt = ncnt_r + ipd_pkg::NAME_CNT_W'(1);
        end
      end
      default: ;
    endcase

    // running sum and checksum capture over the body bytes
    if (in_body) begin
      if (pos_w + ipd_pkg::CMP_W'(3) <= len_w) begin
        u_sum = sum_r + ipd_pkg::SUM_W'(beat.data);
      end
      if (pos_w + ipd_pkg::CMP_W'(2) == len_w) begin
        u_chk[7:0] = beat.data;
      end
      if (pos_w + ipd_pkg::CMP_W'(1) == len_w) begin
        u_chk[15:8] = beat.data;
      end
    end

    // end-of-packet checks
    rx_cnt = (beat.kind == ipd_pkg::BK_OVER) ? beat.pos : beat.pos + ipd_pkg::POS_W'(1);
    hb     = {u_len, u_head};
    hsum   = '0;
    for (int k = 0; k < 4; k++) begin
      if (u_len >= 16'(k + 3)) begin
        hsum = hsum + 10'(hb[k]);
      end
    end
    total   = ipd_pkg::SUMCMP_W'(u_sum) + ipd_pkg::SUMCMP_W'(hsum);
    len_m1  = u_len - 16'd1;
    len_m2  = u_len - 16'd2;
    chk_fin = u_chk;
    // short declared length: checksum bytes overlap the header
    if (u_len >= 16'd2 && u_len <= 16'd5) begin
      chk_fin[7:0] = hb[len_m2[1:0]];
    end
    if (u_len >= 16'd2 && u_len <= 16'd4) begin
      chk_fin[15:8] = hb[len_m1[1:0]];
    end

    if (rx_cnt < ipd_pkg::POS_W'(ipd_pkg::MIN_LENGTH)) begin
      st = ipd_pkg::ST_TOO_SHORT;
    end else if (!u_hm) begin
      st = ipd_pkg::ST_BAD_HEADER;
    end else if (u_type != exp_type_r) begin
      st = ipd_pkg::ST_OTHER_TYPE;
    end else if (u_len < 16'd2 ||
                 ipd_pkg::CMP_W'(u_len) > ipd_pkg::CMP_W'(rx_cnt)) begin
      st = ipd_pkg::ST_BAD_LENGTH;
    end else if (total != ipd_pkg::SUMCMP_W'(chk_fin)) begin
      st = ipd_pkg::ST_BAD_CHECKSUM;
    end else begin
      st = ipd_pkg::ST_OK;
    end

    res_nxt.status = st;
    if (st == ipd_pkg::ST_OK) begin
      res_nxt.packet_number    = {u_fld[1], u_fld[0]};
      res_nxt.flag_bits        = {u_fld[5], u_fld[4], u_fld[3], u_fld[2]};
      res_nxt.time_fields      = {u_fld[12], u_fld[11], u_fld[10], u_fld[9],
                                  u_fld[8], u_fld[7], u_fld[6]};
      res_nxt.speed_hundredths = {u_fld[14], u_fld[13]};
      res_nxt.km_post          = {u_fld[18], u_fld[17], u_fld[16], u_fld[15]};
      res_nxt.serial_number    = {u_fld[20], u_fld[19]};
      res_nxt.outside_temp     = u_fld[21];
      res_nxt.heading_status   = u_fld[22];
      res_nxt.carriage_number  = u_fld[23];
      res_nxt.train_number     = u_name;
    end else begin
      res_nxt.packet_number    = '0;
      res_nxt.flag_bits        = '0;
      res_nxt.time_fields      = '0;
      res_nxt.speed_hundredths = '0;
      res_nxt.km_post          = '0;
      res_nxt.serial_number    = '0;
      res_nxt.outside_temp     = '0;
      res_nxt.heading_status   = '0;
      res_nxt.carriage_number  = '0;
      res_nxt.train_number     = '0;
    end

    out_valid_nxt = out_valid_r && !out_beat.ready;
    hm_nxt   = hm_r;
    head_nxt = head_r;
    len_nxt  = len_r;
    type_nxt = type_r;
    sum_nxt  = sum_r;
    chk_nxt  = chk_r;
    fld_nxt  = fld_r;
    name_nxt = name_r;
    ncnt_nxt = ncnt_r;
    if (beat_take) begin
      if (beat.last) begin
        out_valid_nxt = 1'b1;
        hm_nxt   = 1'b1;
        head_nxt = '0;
        len_nxt  = '0;
        type_nxt = '0;
        sum_nxt  = '0;
        chk_nxt  = '0;
        fld_nxt  = '0;
        name_nxt = '0;
        ncnt_nxt = '0;
      end else begin
        hm_nxt   = u_hm;
        head_nxt = u_head;
        len_nxt  = u_len;
        type_nxt = u_type;
        sum_nxt  = u_sum;
        chk_nxt  = u_chk;
        fld_nxt  = u_fld;
        name_nxt = u_name;
        ncnt_nxt = u_ncnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= ipd_pkg::SYNC_RESET;
      exp_type_r  <= ipd_pkg::TYPE_RESET;
      hm_r        <= 1'b1;
      head_r      <= '0;
      len_r       <= '0;
      type_r      <= '0;
      sum_r       <= '0;
      chk_r       <= '0;
      fld_r       <= '0;
      name_r      <= '0;
      ncnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sync_r      <= sync_nxt;
      exp_type_r  <= exp_type_nxt;
      hm_r        <= hm_nxt;
      head_r      <= head_nxt;
      len_r       <= len_nxt;
      type_r      <= type_nxt;
      sum_r       <= sum_nxt;
      chk_r       <= chk_nxt;
      fld_r       <= fld_nxt;
      name_r      <= name_nxt;
      ncnt_r      <= ncnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_take && beat.last) begin
      res_r <= res_nxt;
    end
  end

  assign out_beat.valid            = out_valid_r;
  assign out_beat.status           = res_r.status;
  assign out_beat.packet_number    = res_r.packet_number;
  assign out_beat.flag_bits        = res_r.flag_bits;
  assign out_beat.time_fields      = res_r.time_fields;
  assign out_beat.speed_hundredths = res_r.speed_hundredths;
  assign out_beat.km_post          = res_r.km_post;
  assign out_beat.serial_number    = res_r.serial_number;
  assign out_beat.outside_temp     = res_r.outside_temp;
  assign out_beat.heading_status   = res_r.heading_status;
  assign out_beat.carriage_number  = res_r.carriage_number;
  assign out_beat.train_number     = res_r.train_number;

endmodule

[sv/info_packet_deframer.sv]
// channel   dir  handshake     payload
// in_beat   in   valid/ready   data_byte[7:0], last_byte
// out_beat  out  valid/ready   status[2:0] and the decoded packet fields
// cfg_*     in   cfg_we        cfg_index (0 sync byte, 1 expected type), cfg_data[15:0]
//
// one byte per cycle sustained unless a stalled result backs up the queue; the byte
// path is position counter, two-entry queue, then the field/sum update in the back end.
// a packet's last byte passes the queue, then its result is registered in the back end.
// a stalled result holds the back end only when the next last byte arrives;
// the queue then fills and in_beat.ready drops.
// rst_n is synchronous; reset restores both config registers to their defaults.
module info_packet_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  ipd_in_if.sink                         in_beat,
  ipd_out_if.source                      out_beat,
  input  logic                           cfg_we,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           q_full, q_push, q_pop, q_head_valid;
  ipd_pkg::beat_t q_in_beat, q_head_beat;

  ipd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_beat),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_beat  (q_in_beat)
  );

  ipd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_beat  (q_in_beat),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_beat  (q_head_beat)
  );

  ipd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .beat_valid (q_head_valid),
    .beat       (q_head_beat),
    .beat_take  (q_pop),
    .out_beat   (out_beat)
  );

`ifndef SYNTHESIS
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat.valid |-> out_beat.status <= 3'(ipd_pkg::ST_BAD_CHECKSUM))
    else $error("result status out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat.valid && out_beat.status != 3'(ipd_pkg::ST_OK)) |->
      (out_beat.packet_number == '0 && out_beat.flag_bits == '0 &&
       out_beat.km_post == '0 && out_beat.train_number == '0))
    else $error("failed packet carries nonzero fields");

  a_ready_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat.valid && !in_beat.ready) |-> q_full && !q_push)
    else $error("byte pushed while queue full");
`endif

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // the block decodes only indexes 0 and 1
  localparam logic [ipd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = ipd_pkg::CFG_IDX_W'(2);
  localparam logic [ipd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = ipd_pkg::CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 8;

  typedef bit [7:0] byte_q_t[$];

  typedef enum {
    PK_GOOD,
    PK_BAD_SYNC,
    PK_BAD_TYPE,
    PK_BAD_LEN,
    PK_BAD_SUM,
    PK_NOISE,
    PK_SHORT
  } pkt_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ipd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ipd_pkg::CFG_DATA_W-1:0] cfg_data;

  ipd_in_if  in_bus();
  ipd_out_if out_bus();

  info_packet_deframer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_bus),
    .out_beat (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // decoder copy: config, per-packet state, pending results
  bit [7:0]          sync_cfg;
  bit [15:0]         type_cfg;
  int unsigned       rx_count;
  bit                hdr_ok;
  bit [15:0]         decl_len;
  bit [15:0]         pkt_type;
  int unsigned       run_sum;
  bit [15:0]         chk_rx;
  bit [63:0]         fld [4];
  bit [3:0]          name_cnt;
  bit [15:0]         head;
  ipd_pkg::result_t  decoded_packets[$];

  int unsigned      errors;
  int unsigned      beats_sent;
  int unsigned      tx_gap_max;
  int unsigned      rx_gap_max;
  int unsigned      rx_wait;
  int unsigned      rx_hold;
  ipd_pkg::result_t want;

  function automatic void clear_packet_state();
    rx_count = 0;
    hdr_ok   = 1'b1;
    decl_len = '0;
    pkt_type = '0;
    run_sum  = 0;
    chk_rx   = '0;
    fld      = '{default: '0};
    name_cnt = '0;
    head     = '0;
  endfunction

  function automatic bit [7:0] hdr_byte(int unsigned i);
    case (i)
      0:       return head[7:0];
      1:       return head[15:8];
      2:       return decl_len[7:0];
      default: return decl_len[15:8];
    endcase
  endfunction

  function automatic bit [63:0] field_le(int unsigned start, int unsigned cnt);
    bit [63:0] v;
    int unsigned o;
    v = '0;
    for (int unsigned k = 0; k < cnt; k++) begin
      o = start + k - ipd_pkg::FLD_FIRST;
      v |= ((fld[o / 8] >> (8 * (o % 8))) & 64'hFF) << (8 * k);
    end
    return v;
  endfunction

  function automatic void decode_byte(bit [7:0] b, bit last);
    int unsigned p;
    int unsigned o;
    int unsigned sum;
    int unsigned len;
    bit [15:0] chk;
    ipd_pkg::status_t st;
    ipd_pkg::result_t r;
    if (rx_count < ipd_pkg::MAX_PACKET) begin
      p = rx_count;
      if (p < 2) begin
        if (b != sync_cfg) hdr_ok = 1'b0;
        head[8 * p +: 8] = b;
      end else if (p == 2) begin
        decl_len = {8'h00, b};
      end else if (p == 3) begin
        decl_len[15:8] = b;
      end else if (p == 4) begin
        pkt_type = {8'h00, b};
      end else if (p == 5) begin
        pkt_type[15:8] = b;
      end
      if (p >= ipd_pkg::SUM_FIRST) begin
        if (p + 3 <= decl_len) run_sum += b;
        if (p + 2 == decl_len) chk_rx[7:0] = b;
        if (p + 1 == decl_len) chk_rx[15:8] = b;
      end
      if (p >= ipd_pkg::FLD_FIRST && p < ipd_pkg::FLD_FIRST + ipd_pkg::FLD_BYTES) begin
        o = p - ipd_pkg::FLD_FIRST;
        fld[o / 8] |= 64'(b) << (8 * (o % 8));
      end else if (p >= ipd_pkg::NAME_FIRST &&
                   p < ipd_pkg::NAME_FIRST + ipd_pkg::NAME_BYTES && b != 0) begin
        // train name keeps only nonzero characters, packed downward
        fld[3] |= 64'(b) << (8 * name_cnt[2:0]);
        name_cnt++;
      end
      rx_count = p + 1;
    end

    if (!last) return;

    len = decl_len;
    if (rx_count < ipd_pkg::MIN_LENGTH) st = ipd_pkg::ST_TOO_SHORT;
    else if (!hdr_ok) st = ipd_pkg::ST_BAD_HEADER;
    else if (pkt_type != type_cfg) st = ipd_pkg::ST_OTHER_TYPE;
    else if (len < 2 || len > rx_count) st = ipd_pkg::ST_BAD_LENGTH;
    else begin
      // short declared lengths pull sum and checksum from the header bytes
      sum = run_sum;
      chk = chk_rx;
      for (int unsigned k = 0; k < 4; k++)
        if (k + 3 <= len) sum += hdr_byte(k);
      if (len - 2 < 4) chk[7:0] = hdr_byte(len - 2);
      if (len - 1 < 4) chk[15:8] = hdr_byte(len - 1);
      st = (sum == chk) ? ipd_pkg::ST_OK : ipd_pkg::ST_BAD_CHECKSUM;
    end

    r = '0;
    r.status = st;
    if (st == ipd_pkg::ST_OK) begin
      r.packet_number    = 16'(field_le(6, 2));
      r.flag_bits        = 32'(field_le(8, 4));
      r.time_fields      = 56'(field_le(12, 7));
      r.speed_hundredths = 16'(field_le(19, 2));
      r.km_post          = 32'(field_le(21, 4));
      r.serial_number    = 16'(field_le(25, 2));
      r.outside_temp     = 8'(field_le(27, 1));
      r.heading_status   = 8'(field_le(28, 1));
      r.carriage_number  = 8'(field_le(29, 1));
      r.train_number     = fld[3];
    end
    decoded_packets.push_back(r);
    clear_packet_state();
  endfunction

  function automatic void build_packet(ref byte_q_t pkt, input pkt_kind_t kind,
                                       input int dlen, input int extra,
                                       input int unsigned lo, input int unsigned hi);
    int unsigned sum;
    int unsigned total;
    int unsigned v;
    bit [7:0] b;
    pkt.delete();
    if (kind == PK_NOISE || kind == PK_SHORT) begin
      total = (kind == PK_SHORT) ? $urandom_range(1, 4) : $urandom_range(5, 60);
      repeat (total) pkt.push_back(8'($urandom));
      return;
    end
    pkt.push_back(sync_cfg);
    pkt.push_back(sync_cfg);
    pkt.push_back(dlen[7:0]);
    pkt.push_back(dlen[15:8]);
    pkt.push_back(type_cfg[7:0]);
    pkt.push_back(type_cfg[15:8]);
    for (int i = ipd_pkg::FLD_FIRST; i < dlen - 2; i++) begin
      b = 8'($urandom_range(lo, hi));
      if (i >= ipd_pkg::NAME_FIRST && i < ipd_pkg::NAME_FIRST + ipd_pkg::NAME_BYTES &&
          $urandom_range(0, 3) == 0)
        b = 8'h00;
      pkt.push_back(b);
    end
    sum = 0;
    foreach (pkt[i]) sum += pkt[i];
    pkt.push_back(sum[7:0]);
    pkt.push_back(sum[15:8]);
    repeat (extra) pkt.push_back(8'($urandom));
    case (kind)
      PK_BAD_SYNC: pkt[$urandom_range(0, 1)] = sync_cfg ^ 8'($urandom_range(1, 255));
      PK_BAD_TYPE: pkt[4 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      PK_BAD_LEN: begin
        if ($urandom_range(0, 1)) v = $urandom_range(0, 1);
        else v = $urandom_range(pkt.size() + 1, 65535);
        pkt[2] = v[7:0];
        pkt[3] = v[15:8];
      end
      PK_BAD_SUM: pkt[dlen - 2 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      default: return 17;
    endcase
  endfunction

  task automatic send_byte(input bit [7:0] b, input bit last);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last;
    do @(posedge clk); while (!in_bus.ready);
    decode_byte(b, last);
    beats_sent++;
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (decoded_packets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ipd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ipd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ipd_pkg::CFG_SYNC_BYTE) sync_cfg = val[7:0];
    else if (idx == ipd_pkg::CFG_EXPECTED_TYPE) type_cfg = val;
  endtask

  task automatic flag_mismatch(input string fname, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (decoded_packets.size() == 0) begin
        $display("%0t: result with no packet pending, expected none actual status %0d",
                 $time, out_bus.status);
        errors++;
      end else begin
        want = decoded_packets.pop_front();
        if (out_bus.status !== want.status)
          flag_mismatch("status", want.status, out_bus.status);
        if (out_bus.packet_number !== want.packet_number)
          flag_mismatch("packet_number", want.packet_number, out_bus.packet_number);
        if (out_bus.flag_bits !== want.flag_bits)
          flag_mismatch("flag_bits", want.flag_bits, out_bus.flag_bits);
        if (out_bus.time_fields !== want.time_fields)
          flag_mismatch("time_fields", want.time_fields, out_bus.time_fields);
        if (out_bus.speed_hundredths !== want.speed_hundredths)
          flag_mismatch("speed_hundredths", want.speed_hundredths, out_bus.speed_hundredths);
        if (out_bus.km_post !== want.km_post)
          flag_mismatch("km_post", 32'(want.km_post), 32'(out_bus.km_post));
        if (out_bus.serial_number !== want.serial_number)
          flag_mismatch("serial_number", want.serial_number, out_bus.serial_number);
        if (out_bus.outside_temp !== want.outside_temp)
          flag_mismatch("outside_temp", 8'(want.outside_temp), 8'(out_bus.outside_temp));
        if (out_bus.heading_status !== want.heading_status)
          flag_mismatch("heading_status", want.heading_status, out_bus.heading_status);
        if (out_bus.carriage_number !== want.carriage_number)
          flag_mismatch("carriage_number", want.carriage_number, out_bus.carriage_number);
        if (out_bus.train_number !== want.train_number)
          flag_mismatch("train_number", want.train_number, out_bus.train_number);
      end
      rx_wait = $urandom_range(0, rx_gap_max);
    end
  end

  // result side: long hold first, then the per-beat wait
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (rx_hold != 0) begin
        out_bus.ready <= 1'b0;
        rx_hold--;
      end else if (rx_wait != 0) begin
        out_bus.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic test_field_extremes();
    byte_q_t pkt;
    tx_gap_max = 17;
    rx_gap_max = 17;
    build_packet(pkt, PK_GOOD, 40, 0, 255, 255);
    send_packet(pkt);
    settle();
  endtask

  task automatic test_status_codes();
    byte_q_t pkt;
    pkt.delete();
    pkt.push_back(ipd_pkg::SYNC_RESET);
    send_packet(pkt);
    pkt.push_back(ipd_pkg::SYNC_RESET);
    pkt.push_back(8'h08);
    pkt.push_back(8'h00);
    send_packet(pkt);
    build_packet(pkt, PK_BAD_SYNC, 8, 0, 0, 255);
    send_packet(pkt);
    build_packet(pkt, PK_BAD_TYPE, 8, 0, 0, 255);
    send_packet(pkt);
    build_packet(pkt, PK_BAD_LEN, 8, 0, 0, 255);
    send_packet(pkt);
    build_packet(pkt, PK_BAD_SUM, 8, 0, 0, 255);
    send_packet(pkt);
    settle();
  endtask

  // sum past 16 bits can never match the carried checksum
  task automatic test_checksum_wide();
    byte_q_t pkt;
    tx_gap_max = 0;
    rx_gap_max = 3;
    build_packet(pkt, PK_GOOD, 300, 0, 255, 255);
    send_packet(pkt);
    settle();
  endtask

  task automatic test_oversize();
    byte_q_t pkt;
    tx_gap_max = 0;
    rx_gap_max = 0;
    build_packet(pkt, PK_GOOD, ipd_pkg::MAX_PACKET, 14, 0, 30);
    send_packet(pkt);
    settle();
  endtask

  task automatic test_config_regs();
    byte_q_t pkt;
    tx_gap_max = 3;
    rx_gap_max = 3;
    write_reg(CFG_SPARE_A, 16'h1234);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    build_packet(pkt, PK_GOOD, 12, 1, 0, 255);
    send_packet(pkt);
    settle();
    write_reg(ipd_pkg::CFG_SYNC_BYTE, 16'hFF00);
    write_reg(ipd_pkg::CFG_EXPECTED_TYPE, 16'h0000);
    // declared lengths 2..5 take the sum and low checksum byte out of the header, the high byte for 2..4
    for (int len = 2; len <= 5; len++) begin
      pkt.delete();
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      pkt.push_back(8'(len));
      repeat (3) pkt.push_back(8'h00);
      send_packet(pkt);
    end
    settle();
    write_reg(ipd_pkg::CFG_SYNC_BYTE, 16'h00FF);
    write_reg(ipd_pkg::CFG_EXPECTED_TYPE, 16'hFFFF);
    build_packet(pkt, PK_GOOD, 40, 0, 0, 255);
    send_packet(pkt);
    build_packet(pkt, PK_BAD_TYPE, 10, 0, 0, 255);
    send_packet(pkt);
    settle();
  endtask

  task automatic test_backpressure();
    byte_q_t pkt;
    tx_gap_max = 0;
    rx_gap_max = 0;
    rx_hold = 300;
    repeat (10) begin
      build_packet(pkt, PK_GOOD, 8, 0, 0, 255);
      send_packet(pkt);
    end
    settle();
  endtask

  task automatic test_random();
    byte_q_t pkt;
    int unsigned start;
    int unsigned pick;
    pkt_kind_t kind;
    int dlen;
    int extra;
    start = beats_sent;
    while (beats_sent - start < 950) begin
      if ($urandom_range(0, 9) == 0) begin
        settle();
        case ($urandom_range(0, 3))
          0:       write_reg(ipd_pkg::CFG_SYNC_BYTE, {8'($urandom), 8'h00});
          1:       write_reg(ipd_pkg::CFG_SYNC_BYTE, {8'($urandom), 8'hFF});
          default: write_reg(ipd_pkg::CFG_SYNC_BYTE, 16'($urandom));
        endcase
        case ($urandom_range(0, 4))
          0:       write_reg(ipd_pkg::CFG_EXPECTED_TYPE, 16'h0000);
          1:       write_reg(ipd_pkg::CFG_EXPECTED_TYPE, 16'hFFFF);
          2:       write_reg(ipd_pkg::CFG_EXPECTED_TYPE, ipd_pkg::TYPE_RESET);
          default: write_reg(ipd_pkg::CFG_EXPECTED_TYPE, 16'($urandom));
        endcase
      end
      tx_gap_max = pick_idle();
      rx_gap_max = pick_idle();
      pick = $urandom_range(0, 99);
      if (pick < 50) kind = PK_GOOD;
      else if (pick < 58) kind = PK_BAD_SYNC;
      else if (pick < 66) kind = PK_BAD_TYPE;
      else if (pick < 74) kind = PK_BAD_LEN;
      else if (pick < 84) kind = PK_BAD_SUM;
      else if (pick < 92) kind = PK_NOISE;
      else kind = PK_SHORT;
      dlen  = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(8, 40);
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if ($urandom_range(0, 4) == 0) build_packet(pkt, kind, dlen, extra, 0, 10);
      else build_packet(pkt, kind, dlen, extra, 0, 255);
      send_packet(pkt);
    end
    settle();
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= ipd_pkg::CFG_SYNC_BYTE;
    cfg_data         <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= '0;
    in_bus.last_byte <= 1'b0;
    errors     = 0;
    beats_sent = 0;
    rx_wait    = 0;
    rx_hold    = 0;
    tx_gap_max = 0;
    rx_gap_max = 0;
    sync_cfg   = ipd_pkg::SYNC_RESET;
    type_cfg   = ipd_pkg::TYPE_RESET;
    clear_packet_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_status_codes();
    test_checksum_wide();
    test_oversize();
    test_config_regs();
    test_backpressure();
    test_random();

    if (errors == 0 && decoded_packets.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
